[rtl/core/cone_beam_ray_sample_point_generator_top_defines.svh]
// ----------------------------------------------------------------------------
// cone beam ray sample point generator assertion macros
// shared property wrappers for the top level checks
// ----------------------------------------------------------------------------
`ifndef CONE_BEAM_RAY_SAMPLE_POINT_GENERATOR_TOP_DEFINES_SVH
`define CONE_BEAM_RAY_SAMPLE_POINT_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define CBRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cbrs_pkg.sv]
// ----------------------------------------------------------------------------
// cbrs_pkg
// shared types, constants and helpers of the ray sample point generator
// ----------------------------------------------------------------------------
package cbrs_pkg;

  localparam int unsigned MAX_ROWS = 4096;
  localparam int unsigned MAX_COLS = 4096;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned QUO_W    = 32;
  localparam int unsigned CFG_AW   = 3;

  localparam logic [CFG_AW-1:0] REG_PIXEL_SPACING = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SOURCE_Z      = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DETECTOR_Z    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_RANGE_START   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SAMPLE_STEP   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_ROWS_IN_USE   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_COLS_IN_USE   = 3'd6;

  typedef struct packed {
    logic [30:0]        pixel_spacing;
    logic signed [31:0] source_z;
    logic signed [31:0] detector_z;
    logic signed [31:0] range_start;
    logic [30:0]        sample_step;
    logic [12:0]        rows_in_use;
    logic [12:0]        cols_in_use;
  } cfg_t;

  typedef struct packed {
    logic [62:0] mag_x;
    logic [62:0] mag_y;
    logic [62:0] mag_z;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic        degen;
  } num_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic degen;
  } sgn_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/cone_beam_ray_sample_point_generator_top.sv]
// pipeline: 4 front stages, 32 root stages, 32 divide stages and 1 output register
// throughput: one transaction per cycle unless stalled; all stages advance together
// a stalled output holds every stage, so the input waits only while the output is blocked
// reset: asynchronous active low, clears all valid bits and loads register defaults
// ----------------------------------------------------------------------------
// cone_beam_ray_sample_point_generator_top
// perspective ray sample point generator, signed q16.16 with saturation
// ----------------------------------------------------------------------------
`include "cone_beam_ray_sample_point_generator_top_defines.svh"

module cone_beam_ray_sample_point_generator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cbrs_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [31:0]                 cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [39:0]                 s_axis_tdata,  // pixel_row, pixel_col, sample_index
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [95:0]                 m_axis_tdata,  // point_x, point_y, point_z
  output logic                        m_axis_tuser   // degenerate
);

  cbrs_pkg::cfg_t cfg_q;
  logic           pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_spacing <= 31'd65536;
      cfg_q.source_z      <= '0;
      cfg_q.detector_z    <= '0;
      cfg_q.range_start   <= '0;
      cfg_q.sample_step   <= 31'd65536;
      cfg_q.rows_in_use   <= 13'd256;
      cfg_q.cols_in_use   <= 13'd256;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        cbrs_pkg::REG_PIXEL_SPACING: cfg_q.pixel_spacing <= cfg_wdata_i[30:0];
        cbrs_pkg::REG_SOURCE_Z:      cfg_q.source_z      <= cfg_wdata_i;
        cbrs_pkg::REG_DETECTOR_Z:    cfg_q.detector_z    <= cfg_wdata_i;
        cbrs_pkg::REG_RANGE_START:   cfg_q.range_start   <= cfg_wdata_i;
        cbrs_pkg::REG_SAMPLE_STEP:   cfg_q.sample_step   <= cfg_wdata_i[30:0];
        cbrs_pkg::REG_ROWS_IN_USE:   cfg_q.rows_in_use   <= cfg_wdata_i[12:0];
        cbrs_pkg::REG_COLS_IN_USE:   cfg_q.cols_in_use   <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  logic           m_valid_q;
  assign pipe_en       = !m_valid_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  logic           front_vld;
  logic [63:0]    sumsq;
  cbrs_pkg::num_t num;

  cbrs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (pipe_en),
    .valid_i        (s_axis_tvalid),
    .pixel_row_i    (s_axis_tdata[11:0]),
    .pixel_col_i    (s_axis_tdata[23:12]),
    .sample_index_i (s_axis_tdata[33:24]),
    .cfg_i          (cfg_q),
    .valid_o        (front_vld),
    .sumsq_o        (sumsq),
    .num_o          (num)
  );

  logic                          sq_vld;
  logic [cbrs_pkg::ROOT_W-1:0]   root;
  cbrs_pkg::num_t                num_r;

  cbrs_isqrt #(
    .SIDE_W ($bits(cbrs_pkg::num_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (front_vld),
    .rad_i   (sumsq),
    .side_i  (num),
    .valid_o (sq_vld),
    .root_o  (root),
    .side_o  (num_r)
  );

  cbrs_pkg::sgn_t                 sgn_in, sgn;
  logic                           div_vld;
  logic [2:0][cbrs_pkg::QUO_W-1:0] quo;
  logic [2:0]                     ovf;

  assign sgn_in.neg_x = num_r.neg_x;
  assign sgn_in.neg_y = num_r.neg_y;
  assign sgn_in.neg_z = num_r.neg_z;
  assign sgn_in.degen = num_r.degen;

  cbrs_div #(
    .SIDE_W ($bits(cbrs_pkg::sgn_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (sq_vld),
    .den_i   (root),
    .mag_i   ({num_r.mag_z, num_r.mag_y, num_r.mag_x}),
    .side_i  (sgn_in),
    .valid_o (div_vld),
    .quo_o   (quo),
    .ovf_o   (ovf),
    .side_o  (sgn)
  );

  // sign, saturate and offset z from the source
  logic signed [31:0] x_d, y_d, z_d;
  logic [33:0]        zmag;
  logic signed [33:0] zq, zsum;

  assign zmag = ovf[2] ? 34'h100000000 : {2'b00, quo[2]};
  assign zq   = sgn.neg_z ? -$signed(zmag) : $signed(zmag);
  assign zsum = $signed({{2{cfg_q.source_z[31]}}, cfg_q.source_z}) - zq;

  always_comb begin
    if (ovf[0] || quo[0][31]) begin
      x_d = sgn.neg_x ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      x_d = sgn.neg_x ? -$signed(quo[0]) : $signed(quo[0]);
    end
    if (ovf[1] || quo[1][31]) begin
      y_d = sgn.neg_y ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      y_d = sgn.neg_y ? -$signed(quo[1]) : $signed(quo[1]);
    end
    z_d = cbrs_pkg::sat32(64'(zsum));
    if (sgn.degen) begin
      x_d = '0;
      y_d = '0;
      z_d = '0;
    end
  end

  logic [95:0] out_data_q;
  logic        out_degen_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_data_q  <= {z_d, y_d, x_d};
      out_degen_q <= sgn.degen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (pipe_en) begin
      m_valid_q <= div_vld;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_degen_q;

  `CBRS_ASSERT_NOW(a_degen_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 96'd0, "degenerate ray with nonzero point")
  `CBRS_ASSERT_NEXT(a_stall_front, !pipe_en, $stable(front_vld), "front stage moved during stall")
  `CBRS_ASSERT_NEXT(a_stall_div, !pipe_en && div_vld, div_vld, "divider result lost during stall")

endmodule

[rtl/core/cbrs_front.sv]
// ----------------------------------------------------------------------------
// cbrs_front
// offsets, sample distance, squares and numerators in four register stages
// ----------------------------------------------------------------------------
module cbrs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [11:0]     pixel_row_i,
  input  logic [11:0]     pixel_col_i,
  input  logic [9:0]      sample_index_i,
  input  cbrs_pkg::cfg_t  cfg_i,
  output logic            valid_o,
  output logic [63:0]     sumsq_o,
  output cbrs_pkg::num_t  num_o
);

  logic [12:0]        hrows, hcols;
  logic signed [13:0] twr, twc;
  logic signed [10:0] sm1;
  logic signed [45:0] px_d, py_d, px_q, py_q;
  logic signed [41:0] pd_d, pd_q;
  logic               v1_q, v2_q, v3_q, v4_q;

  assign hrows = (cfg_i.rows_in_use > 13'(cbrs_pkg::MAX_ROWS)) ?
                 13'(cbrs_pkg::MAX_ROWS) : cfg_i.rows_in_use;
  assign hcols = (cfg_i.cols_in_use > 13'(cbrs_pkg::MAX_COLS)) ?
                 13'(cbrs_pkg::MAX_COLS) : cfg_i.cols_in_use;
  assign twr   = $signed({1'b0, pixel_row_i, 1'b0}) - $signed({1'b0, hrows});
  assign twc   = $signed({1'b0, pixel_col_i, 1'b0}) - $signed({1'b0, hcols});
  assign sm1   = $signed({1'b0, sample_index_i}) - 11'sd1;
  assign px_d  = $signed({1'b0, cfg_i.pixel_spacing}) * twr;
  assign py_d  = $signed({1'b0, cfg_i.pixel_spacing}) * twc;
  assign pd_d  = $signed({1'b0, cfg_i.sample_step}) * sm1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px_d;
      py_q <= py_d;
      pd_q <= pd_d;
    end
  end

  // stage 2: halve toward zero, saturate
  logic signed [45:0] pxa, pya;
  logic signed [31:0] ox_d, oy_d, dist_d, ox_q, oy_q, dist_q;
  logic signed [32:0] zdiff;
  logic [32:0]        zmag;
  logic [30:0]        dz_d, dz_q;

  assign pxa    = px_q + 46'(px_q[45]);
  assign pya    = py_q + 46'(py_q[45]);
  assign ox_d   = cbrs_pkg::sat32(64'(pxa >>> 1));
  assign oy_d   = cbrs_pkg::sat32(64'(pya >>> 1));
  assign dist_d = cbrs_pkg::sat32(64'(cfg_i.range_start) + 64'(pd_q));
  assign zdiff  = $signed({cfg_i.source_z[31], cfg_i.source_z})
                - $signed({cfg_i.detector_z[31], cfg_i.detector_z});
  assign zmag   = zdiff[32] ? 33'(-zdiff) : zdiff;
  assign dz_d   = (zmag > 33'h07fffffff) ? 31'h7fffffff : zmag[30:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      dist_q <= dist_d;
      dz_q   <= dz_d;
    end
  end

  // stage 3: squares and numerators
  logic [31:0]        ax, ay;
  logic [63:0]        sqx_d, sqy_d, sqx_q, sqy_q;
  logic [61:0]        sqz_d, sqz_q;
  logic signed [63:0] nx_d, ny_d, nz_d, nx_q, ny_q, nz_q;

  assign ax    = ox_q[31] ? (~ox_q + 32'd1) : ox_q;
  assign ay    = oy_q[31] ? (~oy_q + 32'd1) : oy_q;
  assign sqx_d = ax * ax;
  assign sqy_d = ay * ay;
  assign sqz_d = dz_q * dz_q;
  assign nx_d  = dist_q * ox_q;
  assign ny_d  = dist_q * oy_q;
  assign nz_d  = dist_q * $signed({1'b0, dz_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      sqz_q <= sqz_d;
      nx_q  <= nx_d;
      ny_q  <= ny_d;
      nz_q  <= nz_d;
    end
  end

  // stage 4: sum of squares, magnitudes
  logic [63:0]    sum_d;
  cbrs_pkg::num_t num_d;

  assign sum_d       = sqx_q + sqy_q + 64'(sqz_q);
  assign num_d.mag_x = nx_q[63] ? 63'(-nx_q) : nx_q[62:0];
  assign num_d.mag_y = ny_q[63] ? 63'(-ny_q) : ny_q[62:0];
  assign num_d.mag_z = nz_q[63] ? 63'(-nz_q) : nz_q[62:0];
  assign num_d.neg_x = nx_q[63];
  assign num_d.neg_y = ny_q[63];
  assign num_d.neg_z = nz_q[63];
  assign num_d.degen = (sum_d == 64'd0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sumsq_o <= sum_d;
      num_o   <= num_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign valid_o = v4_q;

endmodule

[rtl/core/cbrs_isqrt.sv]
// ----------------------------------------------------------------------------
// cbrs_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module cbrs_isqrt #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [2*cbrs_pkg::ROOT_W-1:0] rad_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [cbrs_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int unsigned RW = cbrs_pkg::ROOT_W;
  localparam int unsigned NS = cbrs_pkg::ROOT_W;

  logic [2*RW-1:0]   rad_q  [0:NS-1];
  logic [RW+1:0]     rem_q  [0:NS-1];
  logic [RW-1:0]     root_q [0:NS-1];
  logic [SIDE_W-1:0] side_q [0:NS-1];
  logic              vld_q  [0:NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [2*RW-1:0]   rad_p;
    logic [RW+1:0]     rem_p;
    logic [RW-1:0]     root_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;
    logic [RW+3:0]     t, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    assign t     = {rem_p, rad_p[2*RW-1 -: 2]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_p[2*RW-3:0], 2'b00};
        rem_q[k]  <= ge ? (RW+2)'(t - trial) : t[RW+1:0];
        root_q[k] <= {root_p[RW-2:0], ge};
        side_q[k] <= side_p;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

[rtl/core/cbrs_div.sv]
// ----------------------------------------------------------------------------
// cbrs_div
// three-lane pipelined restoring divider with a shared divisor
// ----------------------------------------------------------------------------
module cbrs_div #(
  parameter int unsigned SIDE_W = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [cbrs_pkg::QUO_W-1:0]       den_i,
  input  logic [2:0][62:0]                 mag_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic [2:0][cbrs_pkg::QUO_W-1:0]  quo_o,
  output logic [2:0]                       ovf_o,
  output logic [SIDE_W-1:0]                side_o
);

  localparam int unsigned QW = cbrs_pkg::QUO_W;
  localparam int unsigned NS = cbrs_pkg::QUO_W;

  logic [QW-1:0]         den_q  [0:NS-1];
  logic [2:0][QW-1:0]    rem_q  [0:NS-1];
  logic [2:0][QW-1:0]    w_q    [0:NS-1];
  logic [2:0]            ovf_q  [0:NS-1];
  logic [SIDE_W-1:0]     side_q [0:NS-1];
  logic                  vld_q  [0:NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [QW-1:0]      den_p;
    logic [2:0][QW-1:0] rem_p, w_p, rem_n, w_n;
    logic [2:0]         ovf_p;
    logic [SIDE_W-1:0]  side_p;
    logic               vld_p;
    logic [2:0][QW:0]   t;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_p[l] = {1'b0, mag_i[l][62:QW]};
        assign w_p[l]   = mag_i[l][QW-1:0];
        assign ovf_p[l] = ({1'b0, mag_i[l][62:QW]} >= den_i);
      end
      assign den_p  = den_i;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign den_p  = den_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign w_p    = w_q[k-1];
      assign ovf_p  = ovf_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        t[l] = {rem_p[l], w_p[l][QW-1]};
        if (t[l] >= {1'b0, den_p}) begin
          rem_n[l] = QW'(t[l] - {1'b0, den_p});
          w_n[l]   = {w_p[l][QW-2:0], 1'b1};
        end else begin
          rem_n[l] = t[l][QW-1:0];
          w_n[l]   = {w_p[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_p;
        rem_q[k]  <= rem_n;
        w_q[k]    <= w_n;
        ovf_q[k]  <= ovf_p;
        side_q[k] <= side_p;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = w_q[NS-1];
  assign ovf_o   = ovf_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

[tb/tb_cone_beam_ray_sample_point_generator_top.sv]
// ----------------------------------------------------------------------------
// tb_cone_beam_ray_sample_point_generator_top
// drives pixel and sample index transactions through several register
// settings, predicts each sample point in q16.16 and checks the output stream
// ----------------------------------------------------------------------------
module tb_cone_beam_ray_sample_point_generator_top;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               degen;
  } point_t;

  typedef struct {
    bit [11:0] row;
    bit [11:0] col;
    bit [9:0]  sidx;
    bit        known;
    point_t    pt;
  } vec_t;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int     CYCLE_LIMIT = 400000;
  localparam logic [cbrs_pkg::CFG_AW-1:0] REG_UNUSED = 3'd7;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [cbrs_pkg::CFG_AW-1:0]   cfg_addr_i;
  logic [31:0]                   cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [39:0]                   s_axis_tdata;  // pixel_row, pixel_col, sample_index
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [95:0]                   m_axis_tdata;  // point_x, point_y, point_z
  logic                          m_axis_tuser;  // degenerate

  cone_beam_ray_sample_point_generator_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // register copy
  longint unsigned spacing_q, step_q, rows_q, cols_q;
  longint          src_z_q, det_z_q, start_q;

  point_t pending_points[$];
  int     mismatches;
  int     cycles;
  bit     no_idle;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint center_offset(longint unsigned idx, longint unsigned cnt);
    longint tw;
    tw = 2 * longint'(idx) - longint'(cnt);
    return clamp32((longint'(spacing_q) * tw) / 2);
  endfunction

  function automatic point_t sample_point(bit [11:0] row, bit [11:0] col, bit [9:0] sidx);
    point_t p;
    longint unsigned hr, hc, ax, ay, az, sumsq;
    longint ox, oy, dz, len, ray_dist;
    hr = (rows_q > cbrs_pkg::MAX_ROWS) ? cbrs_pkg::MAX_ROWS : rows_q;
    hc = (cols_q > cbrs_pkg::MAX_COLS) ? cbrs_pkg::MAX_COLS : cols_q;
    ox = center_offset(row, hr);
    oy = center_offset(col, hc);
    dz = src_z_q - det_z_q;
    if (dz < 0) dz = -dz;
    if (dz > SAT_HI) dz = SAT_HI;
    ax = (ox < 0) ? -ox : ox;
    ay = (oy < 0) ? -oy : oy;
    az = dz;
    sumsq = ax * ax + ay * ay + az * az;
    p = '{x: 0, y: 0, z: 0, degen: 1'b1};
    if (sumsq != 0) begin
      len = int_sqrt(sumsq);
      ray_dist = clamp32(start_q + (longint'(sidx) - 1) * longint'(step_q));
      p.x = 32'(clamp32((ray_dist * ox) / len));
      p.y = 32'(clamp32((ray_dist * oy) / len));
      p.z = 32'(clamp32(src_z_q - (ray_dist * dz) / len));
      p.degen = 1'b0;
    end
    return p;
  endfunction

  task automatic write_reg(logic [cbrs_pkg::CFG_AW-1:0] a, logic [31:0] d);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= a;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    case (a)
      cbrs_pkg::REG_PIXEL_SPACING: spacing_q = 64'(d[30:0]);
      cbrs_pkg::REG_SOURCE_Z:      src_z_q = longint'(signed'(d));
      cbrs_pkg::REG_DETECTOR_Z:    det_z_q = longint'(signed'(d));
      cbrs_pkg::REG_RANGE_START:   start_q = longint'(signed'(d));
      cbrs_pkg::REG_SAMPLE_STEP:   step_q = 64'(d[30:0]);
      cbrs_pkg::REG_ROWS_IN_USE:   rows_q = 64'(d[12:0]);
      cbrs_pkg::REG_COLS_IN_USE:   cols_q = 64'(d[12:0]);
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [31:0] sp, logic [31:0] sz, logic [31:0] dzv,
                           logic [31:0] rs, logic [31:0] st, logic [31:0] nr,
                           logic [31:0] nc);
    write_reg(cbrs_pkg::REG_PIXEL_SPACING, sp);
    write_reg(cbrs_pkg::REG_SOURCE_Z, sz);
    write_reg(cbrs_pkg::REG_DETECTOR_Z, dzv);
    write_reg(cbrs_pkg::REG_RANGE_START, rs);
    write_reg(cbrs_pkg::REG_SAMPLE_STEP, st);
    write_reg(cbrs_pkg::REG_ROWS_IN_USE, nr);
    write_reg(cbrs_pkg::REG_COLS_IN_USE, nc);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic send(bit [11:0] row, bit [11:0] col, bit [9:0] sidx, bit known,
                      point_t pt);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, sidx, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_points.push_back(known ? pt : sample_point(row, col, sidx));
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic random_items(int n);
    bit [11:0] r, c;
    point_t    dummy;
    dummy = '{x: 0, y: 0, z: 0, degen: 0};
    for (int i = 0; i < n; i++) begin
      r = 12'($urandom_range(0, 4095));
      c = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 9) == 0) begin
        r = 12'(((rows_q > cbrs_pkg::MAX_ROWS) ? cbrs_pkg::MAX_ROWS : rows_q) / 2);
        c = 12'(((cols_q > cbrs_pkg::MAX_COLS) ? cbrs_pkg::MAX_COLS : cols_q) / 2);
      end
      send(r, c, 10'($urandom_range(0, 1023)), 1'b0, dummy);
    end
    drain();
  endtask

  // output side backpressure
  int stall_left;
  always @(posedge clk_i) begin
    if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // output checker
  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction %h", m_axis_tdata);
      end else begin
        e = pending_points.pop_front();
        if (m_axis_tdata[31:0] !== e.x || m_axis_tdata[63:32] !== e.y ||
            m_axis_tdata[95:64] !== e.z || m_axis_tuser !== e.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x %h y %h z %h d %b got x %h y %h z %h d %b",
                     e.x, e.y, e.z, e.degen, m_axis_tdata[31:0], m_axis_tdata[63:32],
                     m_axis_tdata[95:64], m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    vec_t vecs[12];
    point_t zero_pt;
    zero_pt = '{x: 0, y: 0, z: 0, degen: 1'b1};
    vecs = '{
      '{12'd128,  12'd128,  10'd0,    1'b1, zero_pt},
      '{12'd128,  12'd128,  10'd1023, 1'b1, zero_pt},
      '{12'd0,    12'd0,    10'd0,    1'b0, zero_pt},
      '{12'd4095, 12'd4095, 10'd1023, 1'b0, zero_pt},
      '{12'd0,    12'd4095, 10'd512,  1'b0, zero_pt},
      '{12'd4095, 12'd0,    10'd1,    1'b0, zero_pt},
      '{12'd255,  12'd255,  10'd7,    1'b0, zero_pt},
      '{12'd256,  12'd256,  10'd3,    1'b0, zero_pt},
      '{12'd128,  12'd129,  10'd2,    1'b0, zero_pt},
      '{12'd127,  12'd128,  10'd1000, 1'b0, zero_pt},
      '{12'd2730, 12'd1365, 10'd682,  1'b0, zero_pt},
      '{12'd1365, 12'd2730, 10'd341,  1'b0, zero_pt}
    };
    mismatches = 0;
    cycles = 0;
    no_idle = 1'b0;
    stall_left = 0;
    spacing_q = 65536; step_q = 65536; rows_q = 256; cols_q = 256;
    src_z_q = 0; det_z_q = 0; start_q = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    foreach (vecs[i]) send(vecs[i].row, vecs[i].col, vecs[i].sidx, vecs[i].known, vecs[i].pt);
    drain();
    random_items(100);

    // extremes, count zero and count above limit, unused register index
    write_reg(REG_UNUSED, 32'hffffffff);
    load_regs(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'd0, 32'h1fff);
    random_items(100);
    load_regs(32'd1, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'd1, 32'h1fff, 32'd0);
    random_items(100);
    // realistic geometry
    load_regs(32'h8000, 32'h01f40000, 32'hfe0c0000, 32'h00640000, 32'h10000,
              32'd4096, 32'd1);
    random_items(100);
    // equal source and detector z so centered pixels give zero length rays
    load_regs($urandom_range(1, 32'h40000), 32'h00100000, 32'h00100000,
              $urandom, $urandom_range(1, 32'h40000), 2 * $urandom_range(1, 2048),
              2 * $urandom_range(1, 2048));
    random_items(100);
    load_regs($urandom_range(1, 32'h7fffffff), $urandom, $urandom, $urandom,
              $urandom_range(1, 32'h7fffffff), $urandom_range(0, 8191),
              $urandom_range(0, 8191));
    random_items(100);
    no_idle = 1'b1;
    load_regs($urandom_range(1, 32'h100000), $urandom, $urandom, $urandom,
              $urandom_range(1, 32'h100000), $urandom_range(1, 4096),
              $urandom_range(1, 4096));
    random_items(150);

    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
